// ===== rtl/cfsd_pkg.sv =====
// ----------------------------------------------------------------------------
// cfsd_pkg: shared types and constants for circular free-server dispatch
// Field widths, result kind codes, queue depth and the queued item format.
// ----------------------------------------------------------------------------
package cfsd_pkg;

	// default number of server slots in hardware
	localparam int NUM_SERVERS_DEF = 16;

	// field widths
	localparam int TIME_W  = 31;
	localparam int BUSY_W  = 32;
	localparam int COUNT_W = 20;
	localparam int ID_W    = 6;
	localparam int KIND_W  = 2;
	localparam int SC_W    = 5;
	// effective server count, holds up to 127
	localparam int K_W     = 7;

	localparam logic [SC_W-1:0]    SC_RESET  = SC_W'(16);
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_ASSIGNED = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DROPPED  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_BUSIEST  = 2'd2;

	// queue between front and back
	localparam int QDEPTH = 2;

	// one classified transaction as it waits in the queue
	typedef struct packed {
		logic              report;
		logic [TIME_W-1:0] arrival;
		logic [TIME_W-1:0] load;
	} item_t;

endpackage

// ===== rtl/cfsd_front.sv =====
// ----------------------------------------------------------------------------
// cfsd_front: request intake and queue
// Accepts transactions, classifies them as dispatch or report, and holds
// them in a short queue so the back end can stall on its own.
// ----------------------------------------------------------------------------
module cfsd_front
	import cfsd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  logic              func,
	input  logic [TIME_W-1:0] arrival_time,
	input  logic [TIME_W-1:0] load_time,
	output logic              head_valid,
	output item_t             head,
	input  logic              pop
);

	localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCW = $clog2(QDEPTH + 1);

	item_t          q_mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QCW-1:0] count_q;
	logic           push;
	item_t          item_in;

	// classify incoming transaction
	always_comb begin
		item_in.report  = func;
		item_in.arrival = arrival_time;
		item_in.load    = load_time;
	end

	assign req_stall  = (count_q == QCW'(QDEPTH));
	assign push       = req_valid && !req_stall;
	assign head_valid = (count_q != '0);
	assign head       = q_mem_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= item_in;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCW'(QDEPTH))
		else $error("queue fill count above depth");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("pop from empty queue");
`endif

endmodule

// ===== rtl/cfsd_back.sv =====
// ----------------------------------------------------------------------------
// cfsd_back: server table, circular search and busiest-server report
// Holds per-server busy-until times and counts, dispatches in IDLE then WRITE
// and sweeps the table for reports, driving a registered result port.
// ----------------------------------------------------------------------------
module cfsd_back
	import cfsd_pkg::*;
#(
	parameter int NUM_SERVERS = NUM_SERVERS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [K_W-1:0]     k,
	input  logic               head_valid,
	input  item_t              head,
	output logic               pop,
	output logic               res_valid,
	input  logic               res_stall,
	output logic [KIND_W-1:0]  kind,
	output logic [ID_W-1:0]    server_id,
	output logic [COUNT_W-1:0] served_total,
	output logic               last
);

	localparam int IDW = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_WRITE = 2'd1;
	localparam logic [1:0] ST_RMAX  = 2'd2;
	localparam logic [1:0] ST_REMIT = 2'd3;

	logic [1:0]             state_q;
	logic [BUSY_W-1:0]      busy_q [NUM_SERVERS];
	logic [COUNT_W-1:0]     cnt_q  [NUM_SERVERS];
	logic [ID_W-1:0]        next_start_q;
	logic [K_W-1:0]         k_q;
	logic [IDW-1:0]         idx_q;
	logic [COUNT_W-1:0]     best_q;
	logic [IDW-1:0]         last_idx_q;

	// request stage registers
	logic [NUM_SERVERS-1:0] free_s1;
	logic [ID_W-1:0]        start_s1;
	logic [BUSY_W-1:0]      sum_s1;

	// result register
	logic                   res_valid_q;
	logic [KIND_W-1:0]      kind_q;
	logic [ID_W-1:0]        server_id_q;
	logic [COUNT_W-1:0]     served_total_q;
	logic                   last_q;

	logic                   slot_free;
	logic                   res_load;
	logic [NUM_SERVERS-1:0] free_now;
	logic [ID_W-1:0]        start_now;
	logic [NUM_SERVERS-1:0] hi_mask;
	logic [IDW-1:0]         pick;
	logic                   found;
	logic [COUNT_W-1:0]     pick_cnt;
	logic [COUNT_W-1:0]     pick_cnt_inc;
	logic [ID_W-1:0]        start_inc;
	logic [COUNT_W-1:0]     idx_cnt;
	logic                   idx_end;
	logic                   idx_is_last;

	assign slot_free = !res_valid_q || !res_stall;
	assign pop       = (state_q == ST_IDLE) && head_valid;

	// a new result enters the output register this cycle
	assign res_load = slot_free &&
		((state_q == ST_WRITE) || (state_q == ST_REMIT && idx_cnt == best_q));

	// free mask against the head request, limited to the first k servers
	always_comb begin
		for (int i = 0; i < NUM_SERVERS; i++) begin
			free_now[i] = (K_W'(i) < k) && (busy_q[i] <= {1'b0, head.arrival});
		end
		start_now = (K_W'(next_start_q) < k) ? next_start_q : '0;
	end

	// circular priority pick: first free at or after start, else first free
	always_comb begin
		for (int i = 0; i < NUM_SERVERS; i++) begin
			hi_mask[i] = free_s1[i] && (ID_W'(i) >= start_s1);
		end
		pick = '0;
		for (int i = NUM_SERVERS - 1; i >= 0; i--) begin
			if (hi_mask != '0) begin
				if (hi_mask[i]) begin
					pick = IDW'(i);
				end
			end else if (free_s1[i]) begin
				pick = IDW'(i);
			end
		end
		found        = (free_s1 != '0);
		pick_cnt     = cnt_q[pick];
		pick_cnt_inc = (pick_cnt == COUNT_MAX) ? pick_cnt : pick_cnt + 1'b1;
		start_inc    = (K_W'(start_s1) + 1'b1 >= k_q) ? '0 : start_s1 + 1'b1;
	end

	// report sweep helpers
	assign idx_cnt     = cnt_q[idx_q];
	assign idx_end     = (K_W'(idx_q) == k_q - 1'b1);
	assign idx_is_last = (idx_q == last_idx_q);

	// sequencer and server table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			next_start_q <= '0;
			k_q          <= K_W'(1);
			idx_q        <= '0;
			best_q       <= '0;
			last_idx_q   <= '0;
			res_valid_q  <= 1'b0;
			for (int i = 0; i < NUM_SERVERS; i++) begin
				busy_q[i] <= '0;
				cnt_q[i]  <= '0;
			end
		end else begin
			if (slot_free) begin
				res_valid_q <= res_load;
			end
			case (state_q)
				ST_IDLE: begin
					if (head_valid) begin
						k_q        <= k;
						idx_q      <= '0;
						best_q     <= '0;
						last_idx_q <= '0;
						state_q    <= head.report ? ST_RMAX : ST_WRITE;
					end
				end
				ST_WRITE: begin
					if (slot_free) begin
						next_start_q <= start_inc;
						if (found) begin
							busy_q[pick] <= sum_s1;
							cnt_q[pick]  <= pick_cnt_inc;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_RMAX: begin
					if (idx_cnt > best_q) begin
						best_q     <= idx_cnt;
						last_idx_q <= idx_q;
					end else if (idx_cnt == best_q) begin
						last_idx_q <= idx_q;
					end
					if (idx_end) begin
						idx_q   <= '0;
						state_q <= ST_REMIT;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_REMIT: begin
					if (idx_cnt != best_q) begin
						idx_q <= idx_q + 1'b1;
					end else if (slot_free) begin
						idx_q <= idx_q + 1'b1;
						if (idx_is_last) begin
							// final entry: wipe the table
							next_start_q <= '0;
							for (int i = 0; i < NUM_SERVERS; i++) begin
								busy_q[i] <= '0;
								cnt_q[i]  <= '0;
							end
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request stage payload
	always_ff @(posedge clk) begin
		if (pop) begin
			free_s1  <= free_now;
			start_s1 <= start_now;
			sum_s1   <= BUSY_W'(head.arrival) + BUSY_W'(head.load);
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_WRITE && slot_free) begin
			kind_q         <= found ? KIND_ASSIGNED : KIND_DROPPED;
			server_id_q    <= found ? ID_W'(pick) : '0;
			served_total_q <= found ? pick_cnt_inc : '0;
			last_q         <= 1'b1;
		end else if (state_q == ST_REMIT && idx_cnt == best_q && slot_free) begin
			kind_q         <= KIND_BUSIEST;
			server_id_q    <= ID_W'(idx_q);
			served_total_q <= best_q;
			last_q         <= idx_is_last;
		end
	end

	assign res_valid    = res_valid_q;
	assign kind         = kind_q;
	assign server_id    = server_id_q;
	assign served_total = served_total_q;
	assign last         = last_q;

`ifndef NO_ASSERTIONS
	a_free_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE) |-> (K_W'(start_s1) < K_W'(NUM_SERVERS)))
		else $error("search start outside server range");
	a_sweep_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RMAX || state_q == ST_REMIT) |-> (K_W'(idx_q) < k_q))
		else $error("report sweep index beyond server count");
	a_write_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE && slot_free) |=> (res_valid && last && state_q == ST_IDLE))
		else $error("dispatch did not produce a single final result");
`endif

endmodule

// ===== rtl/circular_free_server_dispatch.sv =====
// Each dispatch passes a free-mask compare, then table writeback; no new transaction is
// taken until writeback is done, and writeback waits while results are stalled.
// A report makes one sweep over the k servers in use for the maximum, then a sweep
// emitting matches up to the last busiest server, slowed by result stalls.
// Reset (arst_n low) frees all servers, clears counts and the start index, and sets
// server_count to 16; no clearing pass is needed.
// ----------------------------------------------------------------------------
// circular_free_server_dispatch: top level
// Holds the server-count register and joins the intake queue to the
// dispatch and report engine.
// ----------------------------------------------------------------------------
module circular_free_server_dispatch
	import cfsd_pkg::*;
#(
	parameter int NUM_SERVERS = NUM_SERVERS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [SC_W-1:0]    cfg_wdata,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic               func,
	input  logic [TIME_W-1:0]  arrival_time,
	input  logic [TIME_W-1:0]  load_time,
	output logic               res_valid,
	input  logic               res_stall,
	output logic [KIND_W-1:0]  kind,
	output logic [ID_W-1:0]    server_id,
	output logic [COUNT_W-1:0] served_total,
	output logic               last
);

	logic [SC_W-1:0] server_count_q;
	logic [K_W-1:0]  k_eff;
	logic            head_valid;
	item_t           head;
	logic            pop;

	// server-count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			server_count_q <= SC_RESET;
		end else if (cfg_we) begin
			server_count_q <= cfg_wdata;
		end
	end

	// zero acts as one, values above the hardware count are clamped
	always_comb begin
		if (server_count_q == '0) begin
			k_eff = K_W'(1);
		end else if (K_W'(server_count_q) > K_W'(NUM_SERVERS)) begin
			k_eff = K_W'(NUM_SERVERS);
		end else begin
			k_eff = K_W'(server_count_q);
		end
	end

	cfsd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.func         (func),
		.arrival_time (arrival_time),
		.load_time    (load_time),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop)
	);

	cfsd_back #(
		.NUM_SERVERS (NUM_SERVERS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.k            (k_eff),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.kind         (kind),
		.server_id    (server_id),
		.served_total (served_total),
		.last         (last)
	);

endmodule
